// ----- hdl/fasc_pkg.sv -----
// Shared types, constants and helper functions for the fuzzy ABS slip controller.
// No dependencies; every other file in hdl/ imports this package.
package fasc_pkg;

  typedef struct packed {
    logic               pedal_pressed;
    logic [11:0]        wheel_speed;
    logic signed [15:0] vehicle_accel;
  } in_t;

  typedef struct packed {
    logic signed [10:0] control_signal;
    logic               speed_fault;
  } out_t;

  typedef logic [9:0] tgt_t;

  localparam tgt_t               SLIP_TARGET_RESET = 10'd150;
  localparam logic signed [10:0] IDLE_DRIVE        = -11'sd1000;
  localparam logic [10:0]        SLIP_LIMIT        = 11'd2000;
  localparam logic [10:0]        OUT_LIMIT         = 11'd1000;
  localparam logic [7:0]         WHEEL_RADIUS      = 8'd250;

  // Divider geometry: 40-bit dividend, 32-bit divisor, one quotient bit per cycle.
  localparam int DIV_W = 40;
  localparam int DVS_W = 32;
  localparam int CNT_W = $clog2(DIV_W);

  // sum*20/1000 == sum/50: floor(n/50) == (n * V_RECIP) >> 36 for all n <= 2^31.
  localparam logic [30:0] V_RECIP       = 31'd1374389535;
  localparam int          V_RECIP_SHIFT = 36;
  // floor(n/20) == (n * RATE_RECIP) >> 18 for all n < 2^12.
  localparam logic [13:0] RATE_RECIP       = 14'd13108;
  localparam int          RATE_RECIP_SHIFT = 18;

  // floor(n/125) == (n * RECIP) >> 34 for all n < 2^27.
  localparam logic [27:0] RECIP       = 28'd137438954;
  localparam int          RECIP_SHIFT = 34;

  localparam logic [2:0] SET_LAST = 3'd6;

  localparam logic signed [10:0] RULE_TAB [7][7] = '{
    '{11'sd1000, 11'sd1000, 11'sd1000, 11'sd1000, 11'sd667, 11'sd333, 11'sd0},
    '{11'sd1000, 11'sd1000, 11'sd1000, 11'sd667, 11'sd667, 11'sd0, -11'sd333},
    '{11'sd1000, 11'sd667, 11'sd667, 11'sd333, 11'sd0, -11'sd333, -11'sd667},
    '{11'sd1000, 11'sd667, 11'sd333, 11'sd0, -11'sd333, -11'sd667, -11'sd1000},
    '{11'sd667, 11'sd333, 11'sd0, -11'sd333, -11'sd667, -11'sd667, -11'sd1000},
    '{11'sd333, 11'sd0, -11'sd667, -11'sd667, -11'sd1000, -11'sd1000, -11'sd1000},
    '{11'sd0, -11'sd333, -11'sd667, -11'sd1000, -11'sd1000, -11'sd1000, -11'sd1000}
  };

  typedef enum logic [1:0] {
    DS_V    = 2'd0,
    DS_SLIP = 2'd1,
    DS_RATE = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_REL   = 4'd1,
    ST_ACC   = 4'd2,
    ST_VGO   = 4'd3,
    ST_VWAIT = 4'd4,
    ST_VCHK  = 4'd5,
    ST_SWAIT = 4'd6,
    ST_RGO   = 4'd7,
    ST_RWAIT = 4'd8,
    ST_RULES = 4'd9,
    ST_DRAIN = 4'd10,
    ST_FIN1  = 4'd11,
    ST_FIN2  = 4'd12,
    ST_DONE  = 4'd13
  } st_t;

  typedef struct packed {
    logic     in_take;
    logic     rel_upd;
    logic     acc_upd;
    logic     div_start;
    logic     cq_take;
    div_sel_t div_sel;
    logic     v_take;
    logic     slip_take;
    logic     slip_zero;
    logic     err_take;
    logic     rate_take;
    logic     rule_issue;
    logic     fin_recip;
    logic     res_take;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic v_pos;
    logic rule_last;
    logic pipe_busy;
  } sts_t;

  // Triangular membership degree (0..1000) of set NB..PB; set codes above PB act as PB.
  function automatic logic [9:0] degree(input logic [2:0] set_i, input logic signed [12:0] x);
    logic signed [15:0] xs;
    logic signed [15:0] r;
    xs = {{3{x[12]}}, x};
    r  = 16'sd0;
    case (set_i)
      3'd0: begin
        if (xs <= -16'sd1000) r = 16'sd1000;
        else if (xs < -16'sd500) r = -(16'sd2 * xs) - 16'sd1000;
      end
      3'd1: begin
        if (xs <= -16'sd1000) r = 16'sd0;
        else if (xs <= -16'sd500) r = 16'sd2 * xs + 16'sd2000;
        else if (xs < -16'sd250) r = -(16'sd4 * xs) - 16'sd1000;
      end
      3'd2: begin
        if (xs <= -16'sd500) r = 16'sd0;
        else if (xs <= -16'sd250) r = 16'sd4 * xs + 16'sd2000;
        else if (xs < 16'sd0) r = -(16'sd4 * xs);
      end
      3'd3: begin
        if (xs <= -16'sd250) r = 16'sd0;
        else if (xs <= 16'sd0) r = 16'sd4 * xs + 16'sd1000;
        else if (xs < 16'sd250) r = -(16'sd4 * xs) + 16'sd1000;
      end
      3'd4: begin
        if (xs <= 16'sd0) r = 16'sd0;
        else if (xs <= 16'sd250) r = 16'sd4 * xs;
        else if (xs < 16'sd500) r = -(16'sd4 * xs) + 16'sd2000;
      end
      3'd5: begin
        if (xs <= 16'sd250) r = 16'sd0;
        else if (xs <= 16'sd500) r = 16'sd4 * xs - 16'sd1000;
        else if (xs < 16'sd1000) r = -(16'sd2 * xs) + 16'sd2000;
      end
      default: begin
        if (xs <= 16'sd500) r = 16'sd0;
        else if (xs < 16'sd1000) r = 16'sd2 * xs - 16'sd1000;
        else r = 16'sd1000;
      end
    endcase
    return r[9:0];
  endfunction

endpackage

// ----- hdl/fasc_div.sv -----
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Depends on fasc_pkg for the operand widths.
module fasc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fasc_pkg::DIV_W-1:0] dividend,
  input  logic [fasc_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [fasc_pkg::DIV_W-1:0] quotient
);
  import fasc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;

  assign trial = {rem_r, quo_r[DIV_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/fasc_dp.sv -----
// Datapath: tick state, slip divider, 49-rule product pipeline and result registers.
// Depends on fasc_pkg and fasc_div; driven by fasc_ctrl through cmd_t / sts_t.
module fasc_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  fasc_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  fasc_pkg::tgt_t cfg_wdata,
  input  fasc_pkg::cmd_t cmd,
  output fasc_pkg::sts_t sts,
  output fasc_pkg::out_t out_data
);
  import fasc_pkg::*;

  // tick state
  in_t                in_r, in_nxt;
  tgt_t               tgt_r, tgt_nxt;
  logic [19:0]        sab_r, sab_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [11:0] last_r, last_nxt;
  logic signed [27:0] v_r, v_nxt;
  logic signed [11:0] slip_r, slip_nxt;
  logic               fault_r, fault_nxt;
  logic signed [12:0] err_r, err_nxt;
  logic signed [8:0]  rate_r, rate_nxt;
  logic               neg_r, neg_nxt;
  logic [26:0]        cq_r, cq_nxt;
  // rule pipeline
  logic [2:0]         ri_r, ri_nxt, rj_r, rj_nxt;
  logic               s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic [19:0]        p1_r, p1_nxt;
  logic signed [10:0] tab1_r, tab1_nxt;
  logic [29:0]        mag2_r, mag2_nxt;
  logic               neg2_r, neg2_nxt;
  logic [20:0]        q3_r, q3_nxt;
  logic               neg3_r, neg3_nxt;
  logic signed [21:0] num_r, num_nxt;
  out_t               res_r, res_nxt;
  out_t               out_r, out_nxt;

  // combinational helpers
  logic [DIV_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               dneg;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [19:0]        sab_w;
  logic signed [32:0] acc_sum;
  logic [31:0]        acc_mag;
  logic [62:0]        vprod;
  logic signed [28:0] sd;
  logic signed [38:0] snum;
  logic [38:0]        snum_mag;
  logic signed [12:0] rdiff;
  logic [11:0]        rdiff_mag;
  logic [25:0]        rtprod;
  logic signed [27:0] vq;
  logic [10:0]        ssat;
  logic [31:0]        prod2;
  logic [29:0]        rsrc;
  logic               rneg;
  logic [54:0]        rprod;
  logic [21:0]        num_mag;
  logic [10:0]        rq;

  assign sab_w    = 20'(in_r.wheel_speed * WHEEL_RADIUS);
  assign acc_sum  = {acc_r[31], acc_r} + {{17{in_r.vehicle_accel[15]}}, in_r.vehicle_accel};
  assign acc_mag  = acc_r[31] ? (~acc_r + 32'd1) : acc_r;
  assign vprod    = acc_mag * V_RECIP;
  assign sd       = {v_r[27], v_r} - {9'b0, sab_w};
  assign snum     = {{10{sd[28]}}, sd} * 39'sd1000;
  assign snum_mag = snum[38] ? (~snum + 39'd1) : snum;
  assign rdiff    = {slip_r[11], slip_r} - {last_r[11], last_r};
  assign rdiff_mag = rdiff[12] ? 12'(~rdiff + 13'd1) : rdiff[11:0];
  assign rtprod   = rdiff_mag * RATE_RECIP;
  assign num_mag  = num_r[21] ? (~num_r + 22'd1) : num_r;

  // only the slip division is variable; speed and rate use reciprocals
  assign dvd = DIV_W'(snum_mag);
  assign dvs = DVS_W'(v_r[26:0]);

  always_comb begin
    case (cmd.div_sel)
      DS_V:    dneg = acc_r[31];
      DS_SLIP: dneg = snum[38];
      DS_RATE: dneg = rdiff[12];
      default: dneg = 1'b0;
    endcase
  end

  fasc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign vq    = neg_r ? -{1'b0, cq_r} : {1'b0, cq_r};
  assign ssat  = (quo > DIV_W'(SLIP_LIMIT)) ? SLIP_LIMIT : quo[10:0];
  assign prod2 = {12'b0, p1_r} * {{21{tab1_r[10]}}, tab1_r};
  assign rsrc  = cmd.fin_recip ? 30'(num_mag) : mag2_r;
  assign rneg  = cmd.fin_recip ? num_r[21] : neg2_r;
  assign rprod = rsrc[29:3] * RECIP;
  assign rq    = (q3_r > 21'(OUT_LIMIT)) ? OUT_LIMIT : q3_r[10:0];

  always_comb begin
    in_nxt    = in_r;
    tgt_nxt   = tgt_r;
    sab_nxt   = sab_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    v_nxt     = v_r;
    slip_nxt  = slip_r;
    fault_nxt = fault_r;
    err_nxt   = err_r;
    rate_nxt  = rate_r;
    neg_nxt   = neg_r;
    cq_nxt    = cq_r;
    ri_nxt    = ri_r;
    rj_nxt    = rj_r;
    num_nxt   = num_r;
    res_nxt   = res_r;
    out_nxt   = out_r;

    if (cfg_we) tgt_nxt = cfg_wdata;
    if (cmd.in_take) in_nxt = in_data;
    if (cmd.rel_upd) begin
      sab_nxt  = sab_w;
      acc_nxt  = 32'(in_r.vehicle_accel);
      last_nxt = '0;
      res_nxt.control_signal = IDLE_DRIVE;
      res_nxt.speed_fault    = 1'b0;
    end
    if (cmd.acc_upd) begin
      if (acc_sum > 33'sh0_7FFF_FFFF) acc_nxt = 32'sh7FFF_FFFF;
      else if (acc_sum < -33'sh0_8000_0000) acc_nxt = 32'sh8000_0000;
      else acc_nxt = acc_sum[31:0];
    end
    if (cmd.div_start || cmd.cq_take) neg_nxt = dneg;
    if (cmd.cq_take) begin
      if (cmd.div_sel == DS_RATE)
        cq_nxt = {19'b0, rtprod[25:RATE_RECIP_SHIFT]};
      else
        cq_nxt = vprod[62:V_RECIP_SHIFT];
    end
    if (cmd.v_take) v_nxt = vq + {8'b0, sab_r};
    if (cmd.slip_take) begin
      slip_nxt  = neg_r ? -{1'b0, ssat} : {1'b0, ssat};
      fault_nxt = 1'b0;
    end
    if (cmd.slip_zero) begin
      slip_nxt  = '0;
      fault_nxt = 1'b1;
    end
    if (cmd.err_take) err_nxt = {slip_r[11], slip_r} - {3'b0, tgt_r};
    if (cmd.rate_take) begin
      rate_nxt = neg_r ? -{1'b0, cq_r[7:0]} : {1'b0, cq_r[7:0]};
      last_nxt = slip_r;
      ri_nxt   = '0;
      rj_nxt   = '0;
      num_nxt  = '0;
    end
    if (cmd.rule_issue) begin
      if (rj_r == SET_LAST) begin
        rj_nxt = '0;
        ri_nxt = ri_r + 3'd1;
      end else begin
        rj_nxt = rj_r + 3'd1;
      end
    end
    if (s3_r) num_nxt = num_r + (neg3_r ? -22'(q3_r) : 22'(q3_r));
    if (cmd.res_take) begin
      res_nxt.control_signal = neg3_r ? -{1'b0, rq[9:0]} : {1'b0, rq[9:0]};
      res_nxt.speed_fault    = fault_r;
    end
    if (cmd.out_load) out_nxt = res_r;
  end

  // product pipeline: degrees -> x table -> /1000 -> accumulate
  always_comb begin
    s1_nxt   = cmd.rule_issue;
    p1_nxt   = degree(ri_r, err_r) * degree(rj_r, {{4{rate_r[8]}}, rate_r});
    tab1_nxt = RULE_TAB[ri_r][rj_r];
    s2_nxt   = s1_r;
    neg2_nxt = prod2[31];
    mag2_nxt = prod2[31] ? 30'(~prod2 + 32'd1) : prod2[29:0];
    s3_nxt   = s2_r;
    q3_nxt   = rprod[54:RECIP_SHIFT];
    neg3_nxt = rneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= SLIP_TARGET_RESET;
      sab_r  <= '0;
      acc_r  <= '0;
      last_r <= '0;
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
    end else begin
      tgt_r  <= tgt_nxt;
      sab_r  <= sab_nxt;
      acc_r  <= acc_nxt;
      last_r <= last_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
    end
    in_r    <= in_nxt;
    v_r     <= v_nxt;
    slip_r  <= slip_nxt;
    fault_r <= fault_nxt;
    err_r   <= err_nxt;
    rate_r  <= rate_nxt;
    neg_r   <= neg_nxt;
    cq_r    <= cq_nxt;
    ri_r    <= ri_nxt;
    rj_r    <= rj_nxt;
    p1_r    <= p1_nxt;
    tab1_r  <= tab1_nxt;
    mag2_r  <= mag2_nxt;
    neg2_r  <= neg2_nxt;
    q3_r    <= q3_nxt;
    neg3_r  <= neg3_nxt;
    num_r   <= num_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign sts.div_done  = div_done;
  assign sts.v_pos     = !v_r[27] && (v_r != '0);
  assign sts.rule_last = (ri_r == SET_LAST) && (rj_r == SET_LAST);
  assign sts.pipe_busy = s1_r || s2_r || s3_r;
  assign out_data      = out_r;

endmodule

// ----- hdl/fasc_ctrl.sv -----
// Sequencer for one tick: accumulate, three divisions, rule pass, result hand-off.
// Depends on fasc_pkg; commands fasc_dp and owns both handshakes.
module fasc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_pedal,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  fasc_pkg::sts_t sts,
  output fasc_pkg::cmd_t cmd
);
  import fasc_pkg::*;

  st_t  st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic slot_free;

  assign slot_free = !ov_r || !out_stall;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = in_pedal ? ST_ACC : ST_REL;
      ST_REL:   st_nxt = ST_DONE;
      ST_ACC:   st_nxt = ST_VGO;
      ST_VGO:   st_nxt = ST_VWAIT;
      ST_VWAIT: st_nxt = ST_VCHK;
      ST_VCHK:  st_nxt = sts.v_pos ? ST_SWAIT : ST_RGO;
      ST_SWAIT: if (sts.div_done) st_nxt = ST_RGO;
      ST_RGO:   st_nxt = ST_RWAIT;
      ST_RWAIT: st_nxt = ST_RULES;
      ST_RULES: if (sts.rule_last) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!sts.pipe_busy) st_nxt = ST_FIN1;
      ST_FIN1:  st_nxt = ST_FIN2;
      ST_FIN2:  st_nxt = ST_DONE;
      ST_DONE:  if (slot_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DS_V;
    unique case (st_r)
      ST_IDLE:  cmd.in_take = in_valid;
      ST_REL:   cmd.rel_upd = 1'b1;
      ST_ACC:   cmd.acc_upd = 1'b1;
      ST_VGO:   cmd.cq_take = 1'b1;
      ST_VWAIT: cmd.v_take = 1'b1;
      ST_VCHK: begin
        cmd.div_sel   = DS_SLIP;
        cmd.div_start = sts.v_pos;
        cmd.slip_zero = !sts.v_pos;
      end
      ST_SWAIT: cmd.slip_take = sts.div_done;
      ST_RGO: begin
        cmd.div_sel  = DS_RATE;
        cmd.cq_take  = 1'b1;
        cmd.err_take = 1'b1;
      end
      ST_RWAIT: cmd.rate_take = 1'b1;
      ST_RULES: cmd.rule_issue = 1'b1;
      ST_DRAIN: ;
      ST_FIN1:  cmd.fin_recip = 1'b1;
      ST_FIN2:  cmd.res_take = 1'b1;
      ST_DONE:  cmd.out_load = slot_free;
      default:  ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.out_load) ov_nxt = 1'b1;
    else if (!out_stall) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = ov_r;

endmodule

// ----- hdl/fuzzy_abs_slip_controller.sv -----
// Top level of the fuzzy ABS slip controller: sequencer plus datapath.
// Depends on fasc_pkg, fasc_ctrl, fasc_dp (and fasc_div inside the datapath).
//
//  channel | handshake            | payload           | transfer when
//  --------+----------------------+-------------------+-------------------------
//  in      | in_valid / in_stall  | in_data  (in_t)   | in_valid && !in_stall
//  out     | out_valid / out_stall| out_data (out_t)  | out_valid && !out_stall
//  cfg     | cfg_we               | cfg_wdata (tgt_t) | cfg_we (slip target)
//
// Pedal pressed: the time per item is set by the 40-step bit-serial slip division and
//   the 49-rule pass with its pipeline drain; speed and rate divisions by constants are
//   reciprocal multiplies. Speed zero or below skips the slip division.
// One item in flight; in_stall is high from transfer until the result sits in the
//   output register, which then frees the input side while out_stall holds it.
// Reset (rst_n low, synchronous): sequencer idle, output empty, slip target 150,
//   last slip, brake speed and acceleration sum cleared.
module fuzzy_abs_slip_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fasc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fasc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  fasc_pkg::tgt_t cfg_wdata
);
  import fasc_pkg::*;

  cmd_t cmd;   // sequencer -> datapath strobes
  sts_t sts;   // datapath -> sequencer flags

  // Sequencer: walks accumulate, divisions and rule pass; owns both handshakes.
  fasc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_pedal  (in_data.pedal_pressed),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds tick state, the slip divider and the product pipeline.
  fasc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/fasc_chk.sv -----
// Port-level checker for the fuzzy ABS slip controller, bound to the top level.
// Depends on fasc_pkg for the result payload type.
module fasc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input fasc_pkg::out_t out_data
);
  import fasc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.control_signal >= IDLE_DRIVE) &&
                  (out_data.control_signal <= 11'sd1000))
    else $error("control signal out of range");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice without a busy cycle");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not empty output and free input");

endmodule

bind fuzzy_abs_slip_controller fasc_chk u_chk (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fuzzy_abs_slip_controller: directed table, then random ticks.
// Depends on fasc_pkg and the controller RTL; holds its own slip and fuzzy-rule predictor.
module tb;
  import fasc_pkg::*;

  localparam int NRAND = 550;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  tgt_t cfg_wdata;

  fuzzy_abs_slip_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: mirrors the controller's own registers
  logic [9:0]         pr_target;
  logic signed [31:0] pr_last_slip;
  logic signed [31:0] pr_brake_speed;
  logic signed [31:0] pr_accel_sum;

  out_t drive_q[$];
  int   mismatches;
  bit   lull_active;

  // Rule table, error rows by rate columns (NB..PB)
  int rules [7][7] = '{
    '{1000, 1000, 1000, 1000, 667, 333, 0},
    '{1000, 1000, 1000, 667, 667, 0, -333},
    '{1000, 667, 667, 333, 0, -333, -667},
    '{1000, 667, 333, 0, -333, -667, -1000},
    '{667, 333, 0, -333, -667, -667, -1000},
    '{333, 0, -667, -667, -1000, -1000, -1000},
    '{0, -333, -667, -1000, -1000, -1000, -1000}
  };

  function automatic longint member(int s, longint x);
    case (s)
      0: return (x <= -1000) ? 1000 : (x < -500) ? -2 * x - 1000 : 0;
      1: return (x <= -1000) ? 0 : (x <= -500) ? 2 * x + 2000 :
                (x < -250) ? -4 * x - 1000 : 0;
      2: return (x <= -500) ? 0 : (x <= -250) ? 4 * x + 2000 : (x < 0) ? -4 * x : 0;
      3: return (x <= -250) ? 0 : (x <= 0) ? 4 * x + 1000 :
                (x < 250) ? -4 * x + 1000 : 0;
      4: return (x <= 0) ? 0 : (x <= 250) ? 4 * x : (x < 500) ? -4 * x + 2000 : 0;
      5: return (x <= 250) ? 0 : (x <= 500) ? 4 * x - 1000 :
                (x < 1000) ? -2 * x + 2000 : 0;
      default: return (x <= 500) ? 0 : (x < 1000) ? 2 * x - 1000 : 1000;
    endcase
  endfunction

  // One tick of the controller; updates predictor state and returns the drive
  function automatic out_t predict_drive(in_t t);
    out_t   r;
    longint accel, v, slip, err, rate, num, den, rsum, de, q, sum;
    accel = longint'(t.vehicle_accel);
    r.speed_fault = 1'b0;
    if (!t.pedal_pressed) begin
      pr_brake_speed = 32'(longint'(t.wheel_speed) * 250);
      pr_accel_sum   = 32'(accel);
      pr_last_slip   = 0;
      r.control_signal = IDLE_DRIVE;
      return r;
    end
    sum = longint'(pr_accel_sum) + accel;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    pr_accel_sum = 32'(sum);
    v = sum * 20 / 1000 + longint'(pr_brake_speed);
    if (v <= 0) begin
      slip = 0;
      r.speed_fault = 1'b1;
    end else begin
      slip = (v - longint'(t.wheel_speed) * 250) * 1000 / v;
      if (slip > 2000) slip = 2000;
      if (slip < -2000) slip = -2000;
    end
    err  = slip - longint'(pr_target);
    rate = (slip - longint'(pr_last_slip)) / 20;
    pr_last_slip = 32'(slip);
    rsum = 0;
    for (int j = 0; j < 7; j++) rsum += member(j, rate);
    num = 0;
    den = 0;
    for (int i = 0; i < 7; i++) begin
      de = member(i, err);
      for (int j = 0; j < 7; j++) num += de * member(j, rate) * rules[i][j] / 1000;
      den += de * rsum / 1000;
    end
    q = (den == 0) ? 0 : num / den;
    if (q > 1000) q = 1000;
    if (q < -1000) q = -1000;
    r.control_signal = 11'(q);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("fuzzy_abs_slip_controller regression: fail");
    $finish;
  end

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (lull_active) out_stall <= 1'b1;
      else begin
        mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
        out_stall <= mode ? ($urandom_range(0, 1) == 1) : 1'b0;
      end
    end
  end

  // Check each result transfer against the oldest expected drive
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = drive_q.pop_front();
        if (out_data.control_signal !== want.control_signal ||
            out_data.speed_fault !== want.speed_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected drive %0d fault %0b, got %0d fault %0b",
                     want.control_signal, want.speed_fault,
                     out_data.control_signal, out_data.speed_fault);
        end
      end
    end
  end

  // Offer one tick and hold it until transferred; queue its expected drive
  task automatic send_tick(in_t t, bit typed, out_t typed_drive);
    out_t p;
    p = predict_drive(t);
    if (typed) p = typed_drive;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    drive_q.push_back(p);
    if ($urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_then_write(tgt_t value);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pr_target = value;
  endtask

  function automatic in_t mk(bit p, int w, int a);
    in_t t;
    t.pedal_pressed = p;
    t.wheel_speed   = 12'(w);
    t.vehicle_accel = 16'(a);
    return t;
  endfunction

  typedef struct {
    in_t  tick;
    bit   typed;
    out_t drive;
  } row_t;

  initial begin
    row_t   rows[$];
    in_t    t;
    out_t   idle_out;
    out_t   zero_fault;
    int     burst, wheel;
    tgt_t   targets[5] = '{10'd0, 10'd1000, 10'd1023, 10'd300, 10'd150};

    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_wdata = '0; mismatches = 0; lull_active = 0;
    pr_target = SLIP_TARGET_RESET; pr_last_slip = 0; pr_brake_speed = 0; pr_accel_sum = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_out.control_signal = IDLE_DRIVE; idle_out.speed_fault = 1'b0;
    // After reset with zero speed and sum: v is 0, slip 0, error -150, rate 0;
    // error is 600 NS / 400 ZE, rate fully ZE, so drive is 600 * 333 / 1000
    zero_fault.control_signal = 11'sd199; zero_fault.speed_fault = 1'b1;

    // Directed rows: typed drive only where obvious
    rows.push_back('{mk(1, 0, 0), 1, zero_fault});
    rows.push_back('{mk(0, 4095, 32767), 1, idle_out});
    rows.push_back('{mk(1, 4095, 32767), 0, idle_out});
    rows.push_back('{mk(1, 0, -32768), 0, idle_out});
    rows.push_back('{mk(0, 0, -32768), 1, idle_out});
    rows.push_back('{mk(1, 4095, -32768), 0, idle_out});   // negative v: fault
    rows.push_back('{mk(0, 400, 0), 1, idle_out});
    rows.push_back('{mk(1, 400, 0), 0, idle_out});         // zero slip
    rows.push_back('{mk(1, 300, -5000), 0, idle_out});
    rows.push_back('{mk(1, 100, -9000), 0, idle_out});     // deep slip
    rows.push_back('{mk(1, 4095, 0), 0, idle_out});        // slip saturates low
    rows.push_back('{mk(0, 1, 0), 1, idle_out});
    rows.push_back('{mk(1, 0, 32767), 0, idle_out});       // slip of one unit
    rows.push_back('{mk(1, 2048, 1), 0, idle_out});
    foreach (rows[k]) send_tick(rows[k].tick, rows[k].typed, rows[k].drive);

    // Acceleration sum build-up: a run of maximum samples after a release tick
    send_tick(mk(0, 4095, 32767), 0, idle_out);
    repeat (8) send_tick(mk(1, $urandom_range(0, 4095), 32767), 0, idle_out);

    foreach (targets[ti]) begin
      drain_then_write(targets[ti]);
      for (int n = 0; n < NRAND / 5; n++) begin
        if (ti == 2 && n == 20) begin
          fork
            begin
              lull_active = 1;
              repeat (600) @(posedge clk);
              lull_active = 0;
            end
          join_none
        end
        burst = $urandom_range(0, 9);
        if (burst == 0) t = mk($urandom_range(0, 1), $urandom_range(0, 4095), $urandom);
        else if (burst == 1) t = mk(0, $urandom_range(0, 4095), $urandom_range(0, 65535));
        else begin
          // Well-formed braking: wheel slows against a moderate deceleration
          wheel = (pr_brake_speed / 250) - $urandom_range(0, 120);
          if (wheel < 0) wheel = $urandom_range(0, 30);
          t = mk(1, wheel, -$urandom_range(0, 12000));
          if (pr_brake_speed < 2500)
            t = mk(0, $urandom_range(100, 4095), -$urandom_range(0, 2000));
        end
        send_tick(t, 0, idle_out);
      end
    end

    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0)
      $display("fuzzy_abs_slip_controller regression: pass");
    else
      $display("fuzzy_abs_slip_controller regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fasc_pkg.sv
hdl/fasc_div.sv
hdl/fasc_dp.sv
hdl/fasc_ctrl.sv
hdl/fuzzy_abs_slip_controller.sv
hdl/fasc_chk.sv
tb/sv/tb.sv
